// ===== hdl/pom_pkg.sv =====
// Shared types, widths and reset constants of the perturb-and-observe duty tracker.
`default_nettype none
package pom_pkg;

   localparam int DUTY_BITS  = 8;
   localparam int DUTY_W     = 8;
   localparam int VOLT_W     = 15;
   localparam int CURR_W     = 13;
   localparam int POWER_W    = 28;
   localparam int LIMIT_W    = 27;
   localparam int STEP_W     = 4;
   localparam int BACKOFF_W  = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 27;
   localparam int CALC_W     = DUTY_BITS + 2;

   localparam logic [LIMIT_W-1:0]   POWER_LIMIT_RESET = LIMIT_W'(11000000);
   localparam logic [STEP_W-1:0]    STEP_SIZE_RESET   = STEP_W'(1);
   localparam logic [BACKOFF_W-1:0] BACKOFF_RESET     = BACKOFF_W'(5);
   localparam logic [DUTY_W-1:0]    DUTY_MIN_RESET    = DUTY_W'(10);
   localparam logic [DUTY_W-1:0]    DUTY_MAX_RESET    = DUTY_W'(245);
   localparam logic [DUTY_BITS-1:0] DUTY_RESET        = DUTY_BITS'(30);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POWER_LIMIT = 3'd0,
      CSR_STEP_SIZE   = 3'd1,
      CSR_BACKOFF     = 3'd2,
      CSR_DUTY_MIN    = 3'd3,
      CSR_DUTY_MAX    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [LIMIT_W-1:0]   power_limit_uw;
      logic [STEP_W-1:0]    step_size;
      logic [BACKOFF_W-1:0] backoff_step;
      logic [DUTY_W-1:0]    duty_min;
      logic [DUTY_W-1:0]    duty_max;
   } config_type;

   typedef struct packed {
      logic                      trip;
      logic signed [POWER_W-1:0] power;
   } sample_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      logic              tripped;
      logic              power_limited;
   } result_type;

endpackage
`default_nettype wire

// ===== hdl/pom_req_if.sv =====
// Sample channel interface carrying operation, voltage and current.
`default_nettype none
interface pom_req_if;
   import pom_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     operation;
   logic [VOLT_W-1:0]        voltage_mv;
   logic signed [CURR_W-1:0] current_ma;

   modport source (output valid, output operation, output voltage_mv, output current_ma,
                   input ready);
   modport sink (input valid, input operation, input voltage_mv, input current_ma,
                 output ready);
endinterface
`default_nettype wire

// ===== hdl/pom_rsp_if.sv =====
// Result channel interface carrying duty and status flags.
`default_nettype none
interface pom_rsp_if;
   import pom_pkg::*;

   logic              valid;
   logic              ready;
   logic [DUTY_W-1:0] duty;
   logic              tripped;
   logic              power_limited;

   modport source (output valid, output duty, output tripped, output power_limited,
                   input ready);
   modport sink (input valid, input duty, input tripped, input power_limited,
                 output ready);
endinterface
`default_nettype wire

// ===== hdl/pom_csr_if.sv =====
// Register write channel interface carrying index and data.
`default_nettype none
interface pom_csr_if;
   import pom_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/pom_update.sv =====
// Tracker state registers and the per-sample duty update with clamp.
`default_nettype none
module pom_update (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire pom_pkg::sample_type sample,
   input  wire pom_pkg::config_type cfg,
   output pom_pkg::result_type     result
);
   import pom_pkg::*;

   logic [DUTY_BITS-1:0]      duty_ff, duty_in;
   logic                      step_down_ff, step_down_in;
   logic signed [POWER_W-1:0] prev_power_ff, prev_power_in;
   logic                      trip_latch_ff, trip_latch_in;

   logic                      trip_now;
   logic                      over_limit;
   logic                      step_down_next;
   logic signed [POWER_W-1:0] limit_ext;
   logic signed [CALC_W-1:0]  duty_ext;
   logic signed [CALC_W-1:0]  step_ext;
   logic signed [CALC_W-1:0]  backoff_ext;
   logic signed [CALC_W-1:0]  min_ext;
   logic signed [CALC_W-1:0]  max_ext;
   logic signed [CALC_W-1:0]  duty_raw;
   logic signed [CALC_W-1:0]  duty_clamped;

   always_comb begin
      trip_now       = trip_latch_ff | sample.trip;
      limit_ext      = POWER_W'(cfg.power_limit_uw);
      over_limit     = sample.power > limit_ext;
      step_down_next = (sample.power < prev_power_ff) ? ~step_down_ff : step_down_ff;
      duty_ext       = CALC_W'(duty_ff);
      step_ext       = CALC_W'(cfg.step_size);
      backoff_ext    = CALC_W'(cfg.backoff_step);
      min_ext        = CALC_W'(cfg.duty_min);
      max_ext        = CALC_W'(cfg.duty_max);

      if (over_limit) begin
         duty_raw = duty_ext - backoff_ext;
      end else if (step_down_next) begin
         duty_raw = duty_ext - step_ext;
      end else begin
         duty_raw = duty_ext + step_ext;
      end

      if (duty_raw < min_ext) begin
         duty_clamped = min_ext;
      end else if (duty_raw > max_ext) begin
         duty_clamped = max_ext;
      end else begin
         duty_clamped = duty_raw;
      end

      duty_in       = duty_ff;
      step_down_in  = step_down_ff;
      prev_power_in = prev_power_ff;
      trip_latch_in = trip_latch_ff;
      if (advance) begin
         if (trip_now) begin
            trip_latch_in = 1'b1;
         end else begin
            duty_in       = duty_clamped[DUTY_BITS-1:0];
            step_down_in  = over_limit ? step_down_ff : step_down_next;
            prev_power_in = sample.power;
         end
      end

      result.tripped       = trip_now;
      result.power_limited = ~trip_now & over_limit;
      result.duty          = trip_now ? '0 : duty_clamped[DUTY_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff       <= DUTY_RESET;
         step_down_ff  <= 1'b0;
         prev_power_ff <= '0;
         trip_latch_ff <= 1'b0;
      end else begin
         duty_ff       <= duty_in;
         step_down_ff  <= step_down_in;
         prev_power_ff <= prev_power_in;
         trip_latch_ff <= trip_latch_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/perturb_observe_mppt_duty.sv =====
// Top level of the perturb-and-observe maximum power point duty tracker.
//
// Samples arrive on req_chan: operation 0 carries bus voltage (mV) and signed
// current (mA), operation 1 is an overvoltage comparator trip. Every accepted
// transaction yields exactly one transaction on rsp_chan with the duty, the
// tripped flag and the over-power flag. Registers are written on csr_chan,
// which is always ready; write them only while no transaction is in flight.
//
// The input stage registers the sample and its power product; the next stage
// compares, steps and clamps the duty against the tracker state registers
// and loads the result register. Each sample passes the input stage register
// and then the result register before it shows on rsp_chan, and one
// transaction is taken every cycle when the receiver keeps ready high. When
// the receiver stalls, the result register holds its transaction and the
// input stage still takes one more sample before req_chan.ready falls.
// Reset clears the pipeline, sets duty to 30, the step direction upward, the
// previous power to zero, clears the trip latch and restores the register
// defaults.
`default_nettype none
module perturb_observe_mppt_duty (
   input wire logic  clock,
   input wire logic  reset,
   pom_req_if.sink   req_chan,
   pom_rsp_if.source rsp_chan,
   pom_csr_if.sink   csr_chan
);
   import pom_pkg::*;

   config_type cfg_ff, cfg_in;
   logic       s1_valid_ff, s1_valid_in;
   sample_type s1_sample_ff, s1_sample_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_result_ff, rsp_result_in;
   result_type result_next;

   logic req_accept;
   logic out_free;
   logic advance;

   assign out_free        = ~rsp_valid_ff | rsp_chan.ready;
   assign advance         = s1_valid_ff & out_free;
   assign req_chan.ready  = ~s1_valid_ff | out_free;
   assign req_accept      = req_chan.valid & req_chan.ready;
   assign csr_chan.ready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_POWER_LIMIT: cfg_in.power_limit_uw = csr_chan.data[LIMIT_W-1:0];
            CSR_STEP_SIZE:   cfg_in.step_size      = csr_chan.data[STEP_W-1:0];
            CSR_BACKOFF:     cfg_in.backoff_step   = csr_chan.data[BACKOFF_W-1:0];
            CSR_DUTY_MIN:    cfg_in.duty_min       = csr_chan.data[DUTY_W-1:0];
            CSR_DUTY_MAX:    cfg_in.duty_max       = csr_chan.data[DUTY_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      s1_valid_in        = req_accept | (s1_valid_ff & ~advance);
      s1_sample_in       = s1_sample_ff;
      if (req_accept) begin
         s1_sample_in.trip  = req_chan.operation;
         s1_sample_in.power = POWER_W'($signed({1'b0, req_chan.voltage_mv})
                                       * req_chan.current_ma);
      end
      rsp_valid_in  = advance | (rsp_valid_ff & ~rsp_chan.ready);
      rsp_result_in = advance ? result_next : rsp_result_ff;
   end

   pom_update u_update (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .sample  (s1_sample_ff),
      .cfg     (cfg_ff),
      .result  (result_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.power_limit_uw <= POWER_LIMIT_RESET;
         cfg_ff.step_size      <= STEP_SIZE_RESET;
         cfg_ff.backoff_step   <= BACKOFF_RESET;
         cfg_ff.duty_min       <= DUTY_MIN_RESET;
         cfg_ff.duty_max       <= DUTY_MAX_RESET;
         s1_valid_ff           <= 1'b0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_sample_ff  <= s1_sample_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.duty          = rsp_result_ff.duty;
   assign rsp_chan.tripped       = rsp_result_ff.tripped;
   assign rsp_chan.power_limited = rsp_result_ff.power_limited;

endmodule
`default_nettype wire

// ===== hdl/pom_checker.sv =====
// Port-level checker for the duty tracker and its bind to the top level.
`default_nettype none
module pom_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic [pom_pkg::DUTY_W-1:0] rsp_duty,
   input wire logic                      rsp_tripped,
   input wire logic                      rsp_power_limited
);
   import pom_pkg::*;

   logic seen_trip_ff, seen_trip_in;

   assign seen_trip_in = seen_trip_ff | (rsp_valid & rsp_ready & rsp_tripped);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_trip_ff <= 1'b0;
      end else begin
         seen_trip_ff <= seen_trip_in;
      end
   end

   a_trip_zero_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tripped |-> rsp_duty == '0)
      else $error("Tripped transaction shows a nonzero duty.");

   a_trip_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_trip_ff |-> rsp_tripped)
      else $error("Tripped flag cleared without reset.");

   a_limit_not_tripped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_power_limited |-> !rsp_tripped)
      else $error("Over-power flag raised while tripped.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_duty))
      else $error("Stalled result transaction changed or vanished.");

endmodule

bind perturb_observe_mppt_duty pom_checker u_pom_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_duty          (rsp_chan.duty),
   .rsp_tripped       (rsp_chan.tripped),
   .rsp_power_limited (rsp_chan.power_limited)
);
`default_nettype wire

// ===== bench/perturb_observe_mppt_duty_tb.sv =====
// Self-checking testbench for the perturb-and-observe duty tracker with randomized handshakes.
`timescale 1ns / 100ps
module perturb_observe_mppt_duty_tb;
   import pom_pkg::*;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TRIP   = 1'b1;
   localparam int   LIMIT_TOP = 104857600;
   localparam int   V_TOP     = 32767;
   localparam int   I_TOP     = 3200;
   localparam int   STALL_LIMIT = 3000;
   localparam int   HOLD_CYCLES = 60;
   localparam int   TAIL_CYCLES = 4;

   class duty_scoreboard;
      logic [LIMIT_W-1:0]   power_limit;
      logic [STEP_W-1:0]    step_size;
      logic [BACKOFF_W-1:0] backoff;
      logic [DUTY_W-1:0]    duty_min;
      logic [DUTY_W-1:0]    duty_max;
      logic [DUTY_BITS-1:0] duty;
      logic                 step_down;
      int                   prev_power;
      logic                 tripped;
      result_type           duty_results_due[$];
      int                   mismatches;
      int                   backoffs_seen;
      int                   flips_seen;

      function new();
         power_limit   = POWER_LIMIT_RESET;
         step_size     = STEP_SIZE_RESET;
         backoff       = BACKOFF_RESET;
         duty_min      = DUTY_MIN_RESET;
         duty_max      = DUTY_MAX_RESET;
         duty          = DUTY_RESET;
         step_down     = 1'b0;
         prev_power    = 0;
         tripped       = 1'b0;
         mismatches    = 0;
         backoffs_seen = 0;
         flips_seen    = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_POWER_LIMIT: power_limit = value[LIMIT_W-1:0];
            CSR_STEP_SIZE:   step_size   = value[STEP_W-1:0];
            CSR_BACKOFF:     backoff     = value[BACKOFF_W-1:0];
            CSR_DUTY_MIN:    duty_min    = value[DUTY_W-1:0];
            CSR_DUTY_MAX:    duty_max    = value[DUTY_W-1:0];
            default: ;
         endcase
      endfunction

      function void predict_duty(logic op, logic [VOLT_W-1:0] v, logic signed [CURR_W-1:0] c);
         int         power;
         int         next_duty;
         result_type r;
         r.power_limited = 1'b0;
         if (op == OP_TRIP) tripped = 1'b1;
         if (!tripped) begin
            power     = int'(v) * int'(c);
            next_duty = int'(duty);
            if (power > int'(power_limit)) begin
               next_duty       = next_duty - int'(backoff);
               r.power_limited = 1'b1;
               backoffs_seen++;
            end else begin
               if (power < prev_power) begin
                  step_down = !step_down;
                  flips_seen++;
               end
               next_duty = step_down ? next_duty - int'(step_size)
                                     : next_duty + int'(step_size);
            end
            prev_power = power;
            if (next_duty < int'(duty_min)) next_duty = int'(duty_min);
            else if (next_duty > int'(duty_max)) next_duty = int'(duty_max);
            duty = DUTY_BITS'(next_duty);
         end
         r.duty    = tripped ? '0 : DUTY_W'(duty);
         r.tripped = tripped;
         duty_results_due.push_back(r);
      endfunction

      function void check_duty(result_type got);
         result_type want;
         if (duty_results_due.size() == 0) begin
            $error("Result with no transaction waiting: duty %0d tripped %0b power_limited %0b",
                   got.duty, got.tripped, got.power_limited);
            mismatches++;
            return;
         end
         want = duty_results_due.pop_front();
         if (got.duty !== want.duty) begin
            $error("duty: expected %0d, actual %0d", want.duty, got.duty);
            mismatches++;
         end
         if (got.tripped !== want.tripped) begin
            $error("tripped: expected %0b, actual %0b", want.tripped, got.tripped);
            mismatches++;
         end
         if (got.power_limited !== want.power_limited) begin
            $error("power_limited: expected %0b, actual %0b", want.power_limited,
                   got.power_limited);
            mismatches++;
         end
      endfunction

      function int pending();
         return duty_results_due.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   pom_req_if req_ch();
   pom_rsp_if rsp_ch();
   pom_csr_if csr_ch();

   perturb_observe_mppt_duty u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_ch),
      .rsp_chan (rsp_ch),
      .csr_chan (csr_ch)
   );

   duty_scoreboard board;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_requests;
   int settings_applied;
   int samples_sent;
   int trips_sent;
   int quiet_cycles;
   int walk_v;
   int walk_c;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int hold_served;
      int hold_left;
      hold_served   = 0;
      hold_left     = 0;
      rsp_ch.ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_duty('{duty: rsp_ch.duty, tripped: rsp_ch.tripped,
                               power_limited: rsp_ch.power_limited});
         if (req_ch.valid && req_ch.ready)
            board.predict_duty(req_ch.operation, req_ch.voltage_mv, req_ch.current_ma);
         if (csr_ch.valid && csr_ch.ready)
            board.write_register(csr_index_type'(csr_ch.index), csr_ch.data);
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("perturb_observe_mppt_duty_tb failed");
            $finish;
         end
      end
   end

   task automatic send_item(input logic op, input int v, input int c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.operation  <= op;
      req_ch.voltage_mv <= VOLT_W'(v);
      req_ch.current_ma <= CURR_W'(c);
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      if (op == OP_TRIP) trips_sent++;
      else samples_sent++;
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (board.pending() != 0);
   endtask

   task automatic write_csr(input csr_index_type idx, input int value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= CSR_DATA_W'(value);
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic apply_settings(input int limit, input int step, input int back,
                                 input int dmin, input int dmax);
      drain_results();
      write_csr(CSR_POWER_LIMIT, limit);
      write_csr(CSR_STEP_SIZE, step);
      write_csr(CSR_BACKOFF, back);
      write_csr(CSR_DUTY_MIN, dmin);
      write_csr(CSR_DUTY_MAX, dmax);
      csr_ch.valid <= 1'b0;
      settings_applied++;
   endtask

   task automatic apply_random_settings();
      int limit;
      int dmin;
      int dmax;
      case ($urandom_range(7))
         0:       limit = 0;
         1:       limit = LIMIT_TOP;
         2, 3:    limit = $urandom_range(LIMIT_TOP, 0);
         default: limit = $urandom_range(20000000, 1000000);
      endcase
      if ($urandom_range(3) != 0) begin
         dmin = $urandom_range(60, 0);
         dmax = $urandom_range(255, 180);
      end else begin
         dmin = $urandom_range(255, 0);
         dmax = $urandom_range(255, 0);
      end
      apply_settings(limit, $urandom_range(15, 1), $urandom_range(63, 0), dmin, dmax);
   endtask

   task automatic send_random_sample();
      int pick;
      int c;
      int v;
      pick = $urandom_range(99);
      if (pick < 70) begin
         walk_v = walk_v + $urandom_range(400, 0) - 200;
         walk_c = walk_c + $urandom_range(120, 0) - 60;
         if (walk_v < 0) walk_v = 0;
         if (walk_v > V_TOP) walk_v = V_TOP;
         if (walk_c < -I_TOP) walk_c = -I_TOP;
         if (walk_c > I_TOP) walk_c = I_TOP;
         send_item(OP_SAMPLE, walk_v, walk_c);
      end else if (pick < 85) begin
         c = $urandom_range(I_TOP, 1);
         v = int'(board.power_limit) / c + $urandom_range(4, 0) - 2;
         if (v < 0) v = 0;
         if (v > V_TOP) v = V_TOP;
         send_item(OP_SAMPLE, v, c);
      end else begin
         walk_v = $urandom_range(V_TOP, 0);
         walk_c = $urandom_range(2 * I_TOP, 0) - I_TOP;
         send_item(OP_SAMPLE, walk_v, walk_c);
      end
   endtask

   initial begin
      board            = new();
      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      hold_requests    = 0;
      settings_applied = 0;
      samples_sent     = 0;
      trips_sent       = 0;
      quiet_cycles     = 0;
      walk_v           = 15000;
      walk_c           = 500;
      reset            = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.operation  = OP_SAMPLE;
      req_ch.voltage_mv = '0;
      req_ch.current_ma = '0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = CSR_POWER_LIMIT;
      csr_ch.data       = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_item(OP_SAMPLE, 0, 0);
      send_item(OP_SAMPLE, V_TOP, I_TOP);
      send_item(OP_SAMPLE, V_TOP, -I_TOP);
      send_item(OP_SAMPLE, 1000, 1000);
      send_item(OP_SAMPLE, 1000, 999);
      send_item(OP_SAMPLE, 11000, 1000);
      send_item(OP_SAMPLE, 11001, 1000);
      send_item(OP_SAMPLE, 1, -1);

      apply_settings(0, 15, 63, 0, 255);
      send_item(OP_SAMPLE, 100, 100);
      send_item(OP_SAMPLE, 100, 100);
      send_item(OP_SAMPLE, 0, 0);
      send_item(OP_SAMPLE, 5, -7);

      apply_settings(LIMIT_TOP, 15, 0, 250, 255);
      send_item(OP_SAMPLE, 200, 200);
      send_item(OP_SAMPLE, 200, 200);
      send_item(OP_SAMPLE, 200, 200);

      apply_settings(LIMIT_TOP, 1, 0, 255, 0);
      send_item(OP_SAMPLE, 300, 300);
      send_item(OP_SAMPLE, 300, 300);
      send_item(OP_SAMPLE, 10, 10);

      for (int phase = 0; phase < 12; phase++) begin
         send_idle_pct = (phase < 4) ? 26 : (phase < 8) ? 52 : 0;
         recv_idle_pct = (phase < 4) ? 52 : (phase < 8) ? 26 : 0;
         apply_random_settings();
         for (int n = 0; n < 105; n++) begin
            if ((phase == 1 || phase == 9) && n == 30) hold_requests++;
            if (phase == 5 && n == 50) drain_results();
            send_random_sample();
         end
      end

      send_idle_pct = 0;
      recv_idle_pct = 0;
      apply_settings(int'(board.power_limit), 3, 7, 10, 245);
      send_random_sample();
      send_item(OP_TRIP, $urandom_range(V_TOP, 0), $urandom_range(2 * I_TOP, 0) - I_TOP);
      send_item(OP_SAMPLE, V_TOP, I_TOP);
      send_item(OP_SAMPLE, 0, -I_TOP);
      send_item(OP_TRIP, V_TOP, -1);
      send_random_sample();
      send_item(OP_TRIP, 0, 0);

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d samples and %0d trip events across %0d register settings.",
               samples_sent, trips_sent, settings_applied);
      $display("Saw %0d over-power back-offs and %0d direction reversals.",
               board.backoffs_seen, board.flips_seen);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("perturb_observe_mppt_duty_tb passed");
      else
         $display("perturb_observe_mppt_duty_tb failed");
      $finish;
   end

endmodule
